### rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, status codes and the alphabet lookup of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int CHAR_W   = 8;
  localparam int SEXTET_W = 6;
  localparam int ACC_W    = 18;
  localparam int QUAD_W   = 24;
  localparam int GRP_MAX  = 3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADCHAR = 2'd1;
  localparam logic [1:0] ST_BADLEN  = 2'd2;
  localparam logic [1:0] ST_BADPAD  = 2'd3;

  localparam logic [CHAR_W-1:0] CH_PAD   = 8'h3D;  // '='
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;  // '/'

  typedef struct packed {
    logic                bad;
    logic                pad;
    logic [SEXTET_W-1:0] sext;
  } b64d_cls_t;

  // One decoded quad or one error, handed to the output stage.
  typedef struct packed {
    logic [1:0]                      nbytes;
    logic [GRP_MAX-1:0][CHAR_W-1:0]  data;
    logic [1:0]                      status;
    logic                            fin;
  } b64d_grp_t;

  function automatic b64d_cls_t b64d_classify(input logic [CHAR_W-1:0] c);
    b64d_cls_t   r;
    logic [7:0]  d;
    r = '{bad: 1'b0, pad: 1'b0, sext: '0};
    d = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'd65;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'd71;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c + 8'd4;
    end else if (c == CH_PLUS) begin
      d = 8'd62;
    end else if (c == CH_SLASH) begin
      d = 8'd63;
    end else if (c == CH_PAD) begin
      r.pad = 1'b1;
    end else begin
      r.bad = 1'b1;
    end
    r.sext = d[SEXTET_W-1:0];
    return r;
  endfunction

endpackage

### rtl/b64d_decode.sv
// ----------------------------------------------------------------------------
// b64d_decode
// Input register, sextet gathering, checks and quad/error group forming.
// ----------------------------------------------------------------------------
module b64d_decode import b64d_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              final_char,
  output logic              grp_valid,
  output b64d_grp_t         grp,
  input  logic              grp_ready
);

  logic              iv;
  logic [CHAR_W-1:0] ichar;
  logic              ifin;

  logic [1:0]        quad_pos;
  logic [ACC_W-1:0]  sextet_acc;
  logic [1:0]        pad_seen;
  logic              err_drop;

  logic [1:0]        quad_pos_next;
  logic [ACC_W-1:0]  sextet_acc_next;
  logic [1:0]        pad_seen_next;
  logic              err_drop_next;

  b64d_cls_t           cls;
  logic [1:0]          st;
  logic [1:0]          pad_new;
  logic [SEXTET_W-1:0] sx;
  logic [QUAD_W-1:0]   full;
  logic                quad_end;
  logic                advance;
  logic                accept;

  always_comb begin
    cls = b64d_classify(ichar);
    st  = ST_OK;
    if (cls.bad) begin
      st = ST_BADCHAR;
    end else if (cls.pad) begin
      if (quad_pos < 2'd2) begin
        st = ST_BADPAD;
      end else if (quad_pos == 2'd3 && !ifin) begin
        st = ST_BADPAD;
      end
    end else if (pad_seen != 2'd0) begin
      st = ST_BADPAD;
    end
    if (st == ST_OK && ifin && quad_pos != 2'd3) begin
      st = ST_BADLEN;
    end
    pad_new  = pad_seen + {1'b0, cls.pad};
    sx       = cls.pad ? '0 : cls.sext;
    full     = {sextet_acc, sx};
    quad_end = (quad_pos == 2'd3);
  end

  always_comb begin
    grp_valid = iv && !err_drop && (st != ST_OK || quad_end);
    if (st != ST_OK) begin
      grp.nbytes = 2'd1;
      grp.data   = '0;
    end else begin
      grp.nbytes = pad_new[1] ? 2'd1 : (pad_new[0] ? 2'd2 : 2'd3);
      grp.data   = {full[7:0], full[15:8], full[23:16]};
    end
    grp.status = st;
    grp.fin    = ifin;
  end

  assign advance  = iv && (!grp_valid || grp_ready);
  assign in_stall = iv && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    quad_pos_next   = quad_pos;
    sextet_acc_next = sextet_acc;
    pad_seen_next   = pad_seen;
    err_drop_next   = err_drop;
    if (err_drop || st != ST_OK || quad_end) begin
      if (ifin || quad_end) begin
        quad_pos_next   = '0;
        sextet_acc_next = '0;
        pad_seen_next   = '0;
      end
      if (err_drop) begin
        err_drop_next = !ifin;
      end else if (st != ST_OK) begin
        err_drop_next = !ifin;
      end
    end else begin
      quad_pos_next   = quad_pos + 2'd1;
      sextet_acc_next = full[ACC_W-1:0];
      pad_seen_next   = pad_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iv         <= 1'b0;
      quad_pos   <= '0;
      sextet_acc <= '0;
      pad_seen   <= '0;
      err_drop   <= 1'b0;
    end else begin
      if (accept) begin
        iv <= 1'b1;
      end else if (advance) begin
        iv <= 1'b0;
      end
      if (advance) begin
        quad_pos   <= quad_pos_next;
        sextet_acc <= sextet_acc_next;
        pad_seen   <= pad_seen_next;
        err_drop   <= err_drop_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ichar <= in_char;
      ifin  <= final_char;
    end
  end

endmodule

### rtl/b64d_serial.sv
// ----------------------------------------------------------------------------
// b64d_serial
// Result register: holds one group and sends its bytes one beat at a time.
// ----------------------------------------------------------------------------
module b64d_serial import b64d_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              grp_valid,
  input  b64d_grp_t         grp,
  output logic              grp_ready,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_byte,
  output logic [1:0]        status,
  output logic              run_last,
  output logic              message_end
);

  logic       busy;
  logic [1:0] idx;
  b64d_grp_t  held;
  logic       out_fire;
  logic       load;

  assign out_valid   = busy;
  assign run_last    = (idx == held.nbytes - 2'd1);
  assign out_byte    = (idx == 2'd0) ? held.data[0] :
                       (idx == 2'd1) ? held.data[1] : held.data[2];
  assign status      = held.status;
  assign message_end = run_last && held.fin;

  assign out_fire  = busy && !out_stall;
  assign grp_ready = !busy || (out_fire && run_last);
  assign load      = grp_valid && grp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (out_fire) begin
      if (run_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= grp;
    end
  end

endmodule

### rtl/base64_decoder_with_check.sv
// ----------------------------------------------------------------------------
// base64_decoder_with_check
// Streaming base64 decoder with alphabet, padding and length checks.
// ----------------------------------------------------------------------------
//   channel | signals                                   | beat
//   in      | in_valid, in_stall, in_char, final_char   | one text character
//   out     | out_valid, out_stall, out_byte, status,   | one byte or error
//           | run_last, message_end                     |
//
// Characters enter at one per cycle while in_stall is low; a character lands
// in the input register and is decoded the next cycle. A quad end or a fault
// forms a group of up to three results in the result register, sent one beat
// per cycle while out_stall is low. A character that forms a group waits in
// the input register, and holds the input, until the result register sends
// its last beat.
// Reset (rst, synchronous) empties both registers and clears the quad state.
module base64_decoder_with_check import b64d_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              final_char,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_byte,
  output logic [1:0]        status,
  output logic              run_last,
  output logic              message_end
);

  logic      grp_valid;
  logic      grp_ready;
  b64d_grp_t grp;

  b64d_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char    (in_char),
    .final_char (final_char),
    .grp_valid  (grp_valid),
    .grp        (grp),
    .grp_ready  (grp_ready)
  );

  b64d_serial u_serial (
    .clk         (clk),
    .rst         (rst),
    .grp_valid   (grp_valid),
    .grp         (grp),
    .grp_ready   (grp_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .status      (status),
    .run_last    (run_last),
    .message_end (message_end)
  );

endmodule

### rtl/b64d_checker.sv
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks of the base64 decoder's result stream.
// ----------------------------------------------------------------------------
module b64d_checker import b64d_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CHAR_W-1:0] out_byte,
  input logic [1:0]        status,
  input logic              run_last,
  input logic              message_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(status)
      && $stable(run_last) && $stable(message_end))
    else $error("result beat changed while stalled");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> run_last && out_byte == '0)
    else $error("error beat is not a single zero beat");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_end |-> run_last)
    else $error("message end before the last beat of its group");

  a_err_after_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !run_last |=> out_valid && status == ST_OK)
    else $error("group broken before its last beat");

endmodule

bind base64_decoder_with_check b64d_checker u_b64d_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_byte    (out_byte),
  .status      (status),
  .run_last    (run_last),
  .message_end (message_end)
);
